@@ hdl/afc_pkg.sv @@
// ---------------------------------------------------------------------------
// afc_pkg: shared types and constants for the box cull / detail level unit
// Box and plane layouts, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    localparam int COORD_W     = 16;
    localparam int PLANE_COUNT = 6;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int DIST_W      = 33;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_WIDTH  = 4'd7;

    localparam logic [COORD_W-1:0] CHUNK_WIDTH_RESET = 16'd64;

    // Plane: a, b, c in Q1.14 (a lowest), d in world units (highest)
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] a;
    } plane_t;

    // Box: min_x in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_x;
    } box_t;

endpackage

`default_nettype wire

@@ hdl/afc_plane_test.sv @@
// ---------------------------------------------------------------------------
// afc_plane_test: positive-vertex test of one box against one plane
// Registers the three coefficient products, then sums them with the plane
// offset and reports whether the farthest corner lies behind the plane.
// ---------------------------------------------------------------------------
`default_nettype none

module afc_plane_test
    import afc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire plane_t plane,
    input  wire box_t   box,
    output logic        behind
);

    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [ACC_W-1:0]  acc;

    // Pick the corner farthest along the normal and multiply per axis
    always_comb
    begin
        prod_next[0] = PROD_W'(plane.a)
                     * PROD_W'((plane.a >= 0) ? box.max_x : box.min_x);
        prod_next[1] = PROD_W'(plane.b)
                     * PROD_W'((plane.b >= 0) ? box.max_y : box.min_y);
        prod_next[2] = PROD_W'(plane.c)
                     * PROD_W'((plane.c >= 0) ? box.max_z : box.min_z);
    end

    // Hold products while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= prod_next[0];
            prod_reg[1] <= prod_next[1];
            prod_reg[2] <= prod_next[2];
        end
    end

    // Sum with the offset scaled to Q1.14 and take the sign
    always_comb
    begin
        acc = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2])
            + (ACC_W'(plane.d) <<< 14);
        behind = acc[ACC_W-1];
    end

endmodule

`default_nettype wire

@@ hdl/aabb_frustum_cull_lod_select_unit.sv @@
// A box taken on s_tvalid passes the input, product and result registers in
// turn before its result shows on m_tvalid. Throughput: one box per cycle
// while m_tready allows; set by the three-stage pipeline, which keeps
// accepting while a result waits as long as an internal stage is free.
// Reset: rst_n clears all stage valids, planes and camera to zero, chunk
// width to 64.
// ---------------------------------------------------------------------------
// aabb_frustum_cull_lod_select_unit: box frustum cull and detail level pick
// Six positive-vertex plane tests plus squared ground distance banding.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_cull_lod_select_unit
    import afc_pkg::*;
#(
    parameter int LOD_LEVELS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Box input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z (16 bits each, lowest first)
    input  wire logic [95:0]           s_tdata,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // detail_level [1:0], ground_distance_sq [34:2], zero fill [39:35]
    output logic [39:0]                m_tdata,
    // culled [0]
    output logic                       m_tuser
);

    localparam int NCMP  = (LOD_LEVELS > 1) ? LOD_LEVELS - 1 : 1;
    localparam int LIM_W = 36 + 2 * LOD_LEVELS;
    localparam int DX_W  = COORD_W + 2;
    localparam int SQ_W  = 2 * DX_W;
    localparam int S_W   = 36;

    // Configuration registers
    plane_t                   plane_reg [PLANE_COUNT];
    logic [2*COORD_W-1:0]     camera_reg;
    logic [COORD_W-1:0]       chunk_width_reg;

    // Pipeline
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     ready1, ready2, ready3;
    box_t                     box_reg;
    logic signed [DX_W-1:0]   dx2, dz2;
    logic signed [SQ_W-1:0]   sqx_reg, sqz_reg;
    logic [2*COORD_W-1:0]     w2_reg;
    logic [PLANE_COUNT-1:0]   behind;
    logic [S_W-1:0]           s_sum;
    logic [LIM_W-1:0]         limit0;
    logic [NCMP-1:0]          farther;
    logic [3:0]               level;
    logic                     culled_reg;
    logic [1:0]               level_reg;
    logic [DIST_W-1:0]        dist_reg;

    assign cfg_ready = 1'b1;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
            camera_reg      <= '0;
            chunk_width_reg <= CHUNK_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLANE_LEFT:   plane_reg[0]    <= plane_t'(cfg_data);
                REG_PLANE_RIGHT:  plane_reg[1]    <= plane_t'(cfg_data);
                REG_PLANE_BOTTOM: plane_reg[2]    <= plane_t'(cfg_data);
                REG_PLANE_TOP:    plane_reg[3]    <= plane_t'(cfg_data);
                REG_PLANE_FAR:    plane_reg[4]    <= plane_t'(cfg_data);
                REG_PLANE_NEAR:   plane_reg[5]    <= plane_t'(cfg_data);
                REG_CAMERA:       camera_reg      <= cfg_data[2*COORD_W-1:0];
                REG_CHUNK_WIDTH:  chunk_width_reg <= cfg_data[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Stage readiness: each stage advances when it is empty or drains forward
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: capture the box on transfer
    always_ff @(posedge clk)
    begin
        if (ready1 && s_tvalid)
        begin
            box_reg <= box_t'(s_tdata);
        end
    end

    // Stage 2: plane products
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        afc_plane_test u_plane (
            .clk    (clk),
            .en     (ready2),
            .plane  (plane_reg[p]),
            .box    (box_reg),
            .behind (behind[p])
        );
    end

    // Stage 2: doubled centre offsets, squared; chunk width squared
    always_comb
    begin
        dx2 = DX_W'(box_reg.min_x) + DX_W'(box_reg.max_x)
            - (DX_W'($signed(camera_reg[COORD_W-1:0])) <<< 1);
        dz2 = DX_W'(box_reg.min_z) + DX_W'(box_reg.max_z)
            - (DX_W'($signed(camera_reg[2*COORD_W-1:COORD_W])) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            sqx_reg <= SQ_W'(dx2) * SQ_W'(dx2);
            sqz_reg <= SQ_W'(dz2) * SQ_W'(dz2);
            w2_reg  <= (2*COORD_W)'(chunk_width_reg) * (2*COORD_W)'(chunk_width_reg);
        end
    end

    // Stage 3: four times squared distance and the first band edge
    always_comb
    begin
        s_sum  = S_W'($unsigned(sqx_reg)) + S_W'($unsigned(sqz_reg));
        limit0 = (LIM_W'(w2_reg) << 3) + LIM_W'(w2_reg);
    end

    // Compare against every band edge; edges grow, so the flags are monotone
    always_comb
    begin
        for (int k = 0; k < NCMP; k++)
        begin
            farther[k] = (k + 1 < LOD_LEVELS) && (LIM_W'(s_sum) > (limit0 << (2 * k)));
        end
    end

    // Level is the farthest band edge passed, saturated to the field
    always_comb
    begin
        level = '0;
        for (int k = 0; k < NCMP; k++)
        begin
            if (farther[k])
            begin
                level = 4'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            culled_reg <= |behind;
            level_reg  <= (level > 4'd3) ? 2'd3 : level[1:0];
            dist_reg   <= s_sum[DIST_W+1:2];
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tuser  = culled_reg;
    assign m_tdata  = {5'd0, dist_reg, level_reg};

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the box cull / detail level unit
// Streams boxes through the unit under several plane, camera and chunk width
// settings and checks every result against a cycle-free predictor of the
// plane tests, the squared ground distance and the distance band choice.
// ---------------------------------------------------------------------------

module tb;
    import afc_pkg::*;

    localparam int     LOD_LEVELS     = 4;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RANDOM_PHASES  = 10;
    localparam int     PHASE_BOXES    = 153;
    localparam int     SETTLE_CYCLES  = 8;
    localparam longint Q14_ONE        = 16384;

    // Indexes past the register file; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_CHUNK_WIDTH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = '1;

    typedef struct packed {
        logic              culled;
        logic [1:0]        detail_level;
        logic [DIST_W-1:0] ground_distance_sq;
    } cull_verdict_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tuser;

    aabb_frustum_cull_lod_select_unit #(
        .LOD_LEVELS (LOD_LEVELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the register file
    plane_t                    plane_cfg [PLANE_COUNT];
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_z;
    logic [COORD_W-1:0]        chunk_w;

    box_t          box_queue [$];
    cull_verdict_t predicted_verdicts [$];
    int            boxes_queued   = 0;
    int            boxes_accepted = 0;
    int            failures       = 0;
    int            box_gap        = 0;
    int            stall_left     = 0;
    int            stuck_cycles   = 0;
    logic          box_xfer       = 1'b0;
    logic          sender_gaps_on = 1'b1;
    logic          sink_stalls_on = 1'b1;
    cull_verdict_t seen;
    cull_verdict_t wanted;

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Gap length: mostly none, often short, sometimes long
    function automatic int pick_gap(logic enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Positive-vertex plane tests, half-unit centre offset, squared bands
    function automatic cull_verdict_t predict_cull_lod(box_t b);
        cull_verdict_t      v;
        longint             lo [3];
        longint             hi [3];
        longint             coef [3];
        longint             acc;
        longint             dx2;
        longint             dz2;
        longint unsigned    dist4;
        longint unsigned    band_edge;
        int                 level;
        lo[0] = $signed(b.min_x);
        lo[1] = $signed(b.min_y);
        lo[2] = $signed(b.min_z);
        hi[0] = $signed(b.max_x);
        hi[1] = $signed(b.max_y);
        hi[2] = $signed(b.max_z);
        v.culled = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            coef[0] = $signed(plane_cfg[p].a);
            coef[1] = $signed(plane_cfg[p].b);
            coef[2] = $signed(plane_cfg[p].c);
            acc     = $signed(plane_cfg[p].d);
            acc     = acc * Q14_ONE;
            for (int k = 0; k < 3; k++)
                acc += coef[k] * ((coef[k] >= 0) ? hi[k] : lo[k]);
            if (acc < 0)
                v.culled = 1'b1;
        end
        dx2       = lo[0] + hi[0] - 2 * longint'(camera_x);
        dz2       = lo[2] + hi[2] - 2 * longint'(camera_z);
        dist4     = dx2 * dx2 + dz2 * dz2;
        band_edge = 64'd9 * chunk_w * chunk_w;
        level     = 0;
        while (level + 1 < LOD_LEVELS && dist4 > band_edge)
        begin
            level++;
            band_edge = band_edge * 4;
        end
        if (level > 3)
            level = 3;
        v.detail_level       = 2'(level);
        v.ground_distance_sq = DIST_W'(dist4 >> 2);
        return v;
    endfunction

    // Mirror a register write into the shadow copy
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_BOTTOM,
            REG_PLANE_TOP, REG_PLANE_FAR, REG_PLANE_NEAR:
                plane_cfg[idx[2:0]] = plane_t'(data);
            REG_CAMERA:
            begin
                camera_x = data[15:0];
                camera_z = data[31:16];
            end
            REG_CHUNK_WIDTH:
                chunk_w = data[15:0];
            default:
                ;
        endcase
    endfunction

    function automatic box_t mk_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
        box_t b;
        b.min_x = COORD_W'(mnx);
        b.min_y = COORD_W'(mny);
        b.min_z = COORD_W'(mnz);
        b.max_x = COORD_W'(mxx);
        b.max_y = COORD_W'(mxy);
        b.max_z = COORD_W'(mxz);
        return b;
    endfunction

    // Mostly well-formed boxes within a few bands of the camera, some noise
    function automatic box_t random_box();
        box_t b;
        int   reach;
        int   cx;
        int   cy;
        int   cz;
        int   hx;
        int   hy;
        int   hz;
        if ($urandom_range(0, 9) < 3)
        begin
            b = {$urandom, $urandom, $urandom};
        end
        else
        begin
            reach = (3 * (int'(chunk_w) + 1)) << $urandom_range(0, 3);
            if (reach > 32767)
                reach = 32767;
            cx = int'(camera_x) + int'($urandom_range(0, 2 * reach)) - reach;
            cz = int'(camera_z) + int'($urandom_range(0, 2 * reach)) - reach;
            cy = int'($urandom_range(0, 65535)) - 32768;
            hx = $urandom_range(0, chunk_w / 2 + 1);
            hy = $urandom_range(0, chunk_w / 2 + 1);
            hz = $urandom_range(0, chunk_w / 2 + 1);
            b  = mk_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
            // Turn an occasional box inside out
            if ($urandom_range(0, 19) == 0)
                b = mk_box(cx + hx, cy + hy, cz + hz, cx - hx, cy - hy, cz - hz);
        end
        return b;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_plane();
        if ($urandom_range(0, 1) == 0)
            return '0;
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_box(box_t b);
        box_queue = {box_queue, b};
        boxes_queued++;
    endfunction

    // One register write transfer, then release the channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued box has gone through and been checked
    task automatic wait_drained();
        do @(negedge clk);
        while (box_queue.size() != 0 || boxes_accepted != boxes_queued
               || predicted_verdicts.size() != 0);
    endtask

    // Box driver: hold an offered box until its transfer, then gap or advance
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !box_xfer)
        begin
            s_tvalid <= 1'b1;
        end
        else if (box_gap > 0)
        begin
            s_tvalid <= 1'b0;
            box_gap  <= box_gap - 1;
        end
        else if (box_queue.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= box_queue.pop_front();
            box_gap  <= pick_gap(sender_gaps_on);
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Result sink: random back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap(sink_stalls_on);
        end
    end

    // Monitor: check each result transfer, then predict each box transfer
    always @(posedge clk)
    begin
        box_xfer <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.culled             = m_tuser;
            seen.detail_level       = m_tdata[1:0];
            seen.ground_distance_sq = m_tdata[34:2];
            if (predicted_verdicts.size() == 0)
            begin
                $error("result transfer with no box outstanding");
                failures++;
            end
            else
            begin
                wanted = predicted_verdicts.pop_front();
                if (seen.culled !== wanted.culled)
                begin
                    $error("culled: expected %0d, got %0d", wanted.culled, seen.culled);
                    failures++;
                end
                if (seen.detail_level !== wanted.detail_level)
                begin
                    $error("detail_level: expected %0d, got %0d",
                           wanted.detail_level, seen.detail_level);
                    failures++;
                end
                if (seen.ground_distance_sq !== wanted.ground_distance_sq)
                begin
                    $error("ground_distance_sq: expected %0d, got %0d",
                           wanted.ground_distance_sq, seen.ground_distance_sq);
                    failures++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted_verdicts = {predicted_verdicts, predict_cull_lod(box_t'(s_tdata))};
            boxes_accepted++;
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin
        logic [COORD_W-1:0]    width_pick;
        logic [CFG_DATA_W-1:0] reg_word;

        foreach (plane_cfg[i])
            plane_cfg[i] = '0;
        camera_x = '0;
        camera_z = '0;
        chunk_w  = CHUNK_WIDTH_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: no plane culls; field extremes, inverted box, band edges
        queue_box(mk_box(0, 0, 0, 0, 0, 0));
        queue_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        queue_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        queue_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        queue_box(mk_box(96, 0, 0, 96, 0, 0));
        queue_box(mk_box(96, 0, 0, 97, 0, 0));
        queue_box(mk_box(192, 0, 0, 192, 0, 0));
        queue_box(mk_box(192, 0, 0, 193, 0, 0));
        queue_box(mk_box(384, 0, 0, 384, 0, 0));
        queue_box(mk_box(384, 0, 0, 385, 0, 0));
        queue_box(mk_box(0, 0, -96, 0, 0, -97));
        wait_drained();

        // Simple half-space planes, two zero planes, zero chunk width
        write_reg(REG_PLANE_LEFT,   64'h0000_0000_0000_4000);
        write_reg(REG_PLANE_RIGHT,  64'h03E8_0000_0000_C000);
        write_reg(REG_PLANE_BOTTOM, 64'h0000_0000_0000_0000);
        write_reg(REG_PLANE_TOP,    64'h1388_0000_C000_0000);
        write_reg(REG_PLANE_FAR,    64'h07D0_4000_0000_0000);
        write_reg(REG_PLANE_NEAR,   64'h0000_0000_0000_0000);
        write_reg(REG_CAMERA,       64'h0000_0000_FFCE_0064);
        write_reg(REG_CHUNK_WIDTH,  64'hFFFF_FFFF_FFFF_0000);
        queue_box(mk_box(-5, 0, 0, -1, 0, 0));
        queue_box(mk_box(0, 0, 0, 0, 0, 0));
        queue_box(mk_box(1001, 0, 0, 1100, 0, 0));
        queue_box(mk_box(10, 5001, 0, 20, 6000, 0));
        queue_box(mk_box(100, 0, -50, 100, 0, -50));
        queue_box(mk_box(10, 0, -3000, 20, 0, -2001));
        wait_drained();

        // Extreme coefficients, farthest camera, widest chunk, unmapped indexes
        write_reg(REG_PLANE_LEFT,     64'h8000_8000_8000_8000);
        write_reg(REG_PLANE_RIGHT,    64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_PLANE_BOTTOM,   64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PLANE_TOP,      64'h0001_0001_0001_0001);
        write_reg(REG_PLANE_FAR,      64'h7FFF_8000_7FFF_8000);
        write_reg(REG_PLANE_NEAR,     64'h8000_7FFF_8000_7FFF);
        write_reg(REG_CAMERA,         64'hFFFF_FFFF_8000_8000);
        write_reg(REG_CHUNK_WIDTH,    64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_UNMAPPED_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_UNMAPPED_LAST,  64'h5555_AAAA_5555_AAAA);
        queue_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        queue_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        queue_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_box(mk_box(0, 0, 0, 0, 0, 0));
        queue_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        wait_drained();

        // Random settings per phase; each phase drains before the next write
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            sender_gaps_on = (ph % 3 != 0);
            sink_stalls_on = (ph % 4 != 1);
            for (int r = 0; r < PLANE_COUNT; r++)
                write_reg(REG_PLANE_LEFT + 4'(r), random_plane());
            write_reg(REG_CAMERA, {$urandom, $urandom});
            case (ph)
                0:       width_pick = 16'd1;
                1:       width_pick = 16'd0;
                2:       width_pick = 16'hFFFF;
                default: width_pick = COORD_W'($urandom_range(1, 300));
            endcase
            reg_word       = {$urandom, $urandom};
            reg_word[15:0] = width_pick;
            write_reg(REG_CHUNK_WIDTH, reg_word);
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                          {$urandom, $urandom});
            repeat (PHASE_BOXES) queue_box(random_box());
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ aabb_frustum_cull_lod_select_unit.f @@
hdl/afc_pkg.sv
hdl/afc_plane_test.sv
hdl/aabb_frustum_cull_lod_select_unit.sv
tb/tb.sv
